// ----- rtl/hafe_pkg.sv -----
`timescale 1ns / 1ps

package hafe_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned NibW   = 4;
  localparam int unsigned CharW  = 7;

  localparam logic [CharW-1:0] DigitBase = 7'h30;
  localparam logic [CharW-1:0] AlphaBase = 7'h37;
  localparam logic [NibW-1:0]  NibNine   = 4'd9;

  // Character slot within one byte's output run.
  typedef enum logic [1:0] {
    SLOT_DATA_HI = 2'd0,
    SLOT_DATA_LO = 2'd1,
    SLOT_LRC_HI  = 2'd2,
    SLOT_LRC_LO  = 2'd3
  } slot_e;

  // One byte waiting to be encoded, with the LRC already worked out.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] lrc;
    logic             last;
  } item_t;

  function automatic logic [CharW-1:0] hex_char(input logic [NibW-1:0] nib);
    logic [CharW-1:0] wide;
    wide = {{(CharW-NibW){1'b0}}, nib};
    if (nib <= NibNine) begin
      return wide + DigitBase;
    end
    return wide + AlphaBase;
  endfunction

endpackage

// ----- rtl/hafe_if.sv -----
`timescale 1ns / 1ps

interface hafe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hafe_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;
  logic       last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

// ----- rtl/hafe_accum.sv -----
`timescale 1ns / 1ps

module hafe_accum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [hafe_pkg::ByteW-1:0]  data_byte_i,
  input  logic                        last_byte_i,
  output logic                        item_valid_o,
  input  logic                        item_take_i,
  output hafe_pkg::item_t             item_o
);
  import hafe_pkg::*;

  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] sum_next;
  logic             item_valid_q;
  item_t            item_q;
  logic             accept;

  assign in_ready_o = !item_valid_q || item_take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sum_next   = sum_q + data_byte_i;
  assign sum_d      = last_byte_i ? '0 : sum_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q        <= '0;
      item_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        sum_q        <= sum_d;
        item_valid_q <= 1'b1;
      end else if (item_take_i) begin
        item_valid_q <= 1'b0;
      end
    end
  end

  // LRC is the two's complement of the running sum including this byte.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data <= data_byte_i;
      item_q.lrc  <= (~sum_next) + 1'b1;
      item_q.last <= last_byte_i;
    end
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

endmodule

// ----- rtl/hafe_emit.sv -----
`timescale 1ns / 1ps

module hafe_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  output logic                        item_take_o,
  input  hafe_pkg::item_t             item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hafe_pkg::CharW-1:0]  ascii_char_o,
  output logic                        last_char_o
);
  import hafe_pkg::*;

  slot_e            slot_q, slot_d;
  logic             out_valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             load;
  logic             final_slot;
  logic [NibW-1:0]  nib;

  assign load = item_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    case (slot_q)
      SLOT_DATA_HI: nib = item_i.data[ByteW-1:NibW];
      SLOT_DATA_LO: nib = item_i.data[NibW-1:0];
      SLOT_LRC_HI:  nib = item_i.lrc[ByteW-1:NibW];
      SLOT_LRC_LO:  nib = item_i.lrc[NibW-1:0];
      default:      nib = item_i.data[NibW-1:0];
    endcase
  end

  // A flagged byte runs on through the two LRC slots.
  assign final_slot  = item_i.last ? (slot_q == SLOT_LRC_LO) : (slot_q == SLOT_DATA_LO);
  assign item_take_o = load && final_slot;

  always_comb begin
    slot_d = slot_q;
    if (load) begin
      if (final_slot) begin
        slot_d = SLOT_DATA_HI;
      end else begin
        slot_d = slot_e'(slot_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= SLOT_DATA_HI;
      out_valid_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= hex_char(nib);
      last_q <= (slot_q == SLOT_LRC_LO);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

endmodule

// ----- rtl/hex_ascii_frame_encoder_lrc.sv -----
`timescale 1ns / 1ps

// Hex ASCII frame encoder with LRC.
// in_i carries one frame byte per beat (data_byte) and last_byte on the
// frame's final byte. out_o delivers one upper-case ASCII hex character per
// beat, high nibble first; a flagged byte is followed by the two LRC digits
// (two's complement of the 8-bit frame sum), the second marked by last_char.
// Start colon and CR LF are not produced.
// An accepted byte is held in the input register, and each of its characters
// is then registered in the output register before out_o shows it.
// One character per cycle out of the single output register while out_o is
// ready, so two characters per ordinary byte and four for a frame's final byte.
// The one-entry input register holds the byte being emitted until its last
// character is loaded; in_i.ready is up only while it is empty or freed.
// Stalls on out_o hold the character and back up into in_i.ready; nothing is
// dropped. Reset clears the frame sum and empties both registers.
module hex_ascii_frame_encoder_lrc (
  input  logic      clk_i,
  input  logic      rst_ni,
  hafe_in_if.sink   in_i,
  hafe_out_if.source out_o
);
  import hafe_pkg::*;

  logic  item_valid;
  logic  item_take;
  item_t item;

  hafe_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .data_byte_i  (in_i.data_byte),
    .last_byte_i  (in_i.last_byte),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  hafe_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_i       (item),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .ascii_char_o (out_o.ascii_char),
    .last_char_o  (out_o.last_char)
  );

endmodule

// ----- rtl/hafe_checker.sv -----
`timescale 1ns / 1ps

module hafe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] ascii_char_i,
  input logic       last_char_i
);

  // Output stays empty while reset is held.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  // Every character shown is an upper-case hex digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((ascii_char_i >= 7'h30 && ascii_char_i <= 7'h39) ||
                     (ascii_char_i >= 7'h41 && ascii_char_i <= 7'h46)))
    else $error("character is not a hex digit");

  // An output beat needs an input beat to pass through both registers first;
  // right out of reset nothing can appear before that.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(rst_ni) || !$past(rst_ni)) |-> !out_valid_i)
    else $error("output appeared without input");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(ascii_char_i) &&
                                       $stable(last_char_i)))
    else $error("stalled output beat changed");

endmodule

bind hex_ascii_frame_encoder_lrc hafe_checker u_hafe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .ascii_char_i (out_o.ascii_char),
  .last_char_i  (out_o.last_char)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  import hafe_pkg::ByteW;
  import hafe_pkg::CharW;

  localparam int unsigned ITEM_TARGET   = 430;
  localparam int unsigned CALM_TAIL     = 40;
  localparam int unsigned HOLD_AT_BEAT  = 120;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_AT_BEAT = 280;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned MAX_REPORTS   = 10;

  localparam logic [CharW-1:0] NUM_OFS   = 7'h30;
  localparam logic [CharW-1:0] ALPHA_OFS = 7'h37;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             last;
    bit               drain_before;  // hold off until all chars are out
  } frame_byte_t;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             last;
  } hex_char_t;

  logic clk_i;
  logic rst_ni;

  hafe_in_if  in_bus ();
  hafe_out_if out_bus ();

  hex_ascii_frame_encoder_lrc dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  frame_byte_t      pending_bytes [$];
  hex_char_t        expected_chars [$];
  logic [ByteW-1:0] frame_sum;

  int unsigned n_total;
  int unsigned beats_sent;
  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned in_gap;
  int unsigned out_gap;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  bit          in_taken;
  bit          hold_off;
  bit          quiet;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [CharW-1:0] nibble_to_ascii(input logic [3:0] nib);
    logic [CharW-1:0] wide;
    wide = {3'b000, nib};
    return (nib < 4'd10) ? wide + NUM_OFS : wide + ALPHA_OFS;
  endfunction

  task automatic push_hex_pair(input logic [ByteW-1:0] b, input logic mark);
    hex_char_t c;
    c.ch   = nibble_to_ascii(b[7:4]);
    c.last = 1'b0;
    expected_chars.push_back(c);
    c.ch   = nibble_to_ascii(b[3:0]);
    c.last = mark;
    expected_chars.push_back(c);
  endtask

  // Digits of the byte, then on the frame's final byte the LRC digits.
  task automatic encode_frame_byte(input logic [ByteW-1:0] b, input logic last);
    logic [ByteW-1:0] sum;
    sum = frame_sum + b;
    push_hex_pair(b, 1'b0);
    if (last) begin
      push_hex_pair(~sum + 8'd1, 1'b1);
      frame_sum = '0;
    end else begin
      frame_sum = sum;
    end
  endtask

  task automatic flag_mismatch(input string what, input hex_char_t want,
                               input hex_char_t got);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0t] mismatch (%s): expected char 0x%02h last %0b, got char 0x%02h last %0b",
               $realtime, what, want.ch, want.last, got.ch, got.last);
    end
    mismatches++;
  endtask

  task automatic check_char(input hex_char_t got);
    hex_char_t want;
    if (expected_chars.size() == 0) begin
      want.ch   = '0;
      want.last = 1'b0;
      flag_mismatch("no char pending", want, got);
    end else begin
      want = expected_chars.pop_front();
      if (got.ch !== want.ch) begin
        flag_mismatch("ascii_char", want, got);
      end else if (got.last !== want.last) begin
        flag_mismatch("last_char", want, got);
      end
    end
  endtask

  task automatic add_byte(input logic [ByteW-1:0] b, input logic last, input bit drain);
    frame_byte_t fb;
    fb.data         = b;
    fb.last         = last;
    fb.drain_before = drain;
    pending_bytes.push_back(fb);
  endtask

  // Prediction and checking, both at the rising edge.
  always @(posedge clk_i) begin
    hex_char_t got;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        encode_frame_byte(pending_bytes[0].data, pending_bytes[0].last);
        void'(pending_bytes.pop_front());
        beats_sent++;
        in_taken = 1'b1;
      end
      if (out_bus.valid && out_bus.ready) begin
        got.ch   = out_bus.ascii_char;
        got.last = out_bus.last_char;
        check_char(got);
      end
    end
    quiet = (beats_sent + CALM_TAIL >= n_total);
  end

  // Byte driver
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) in_idle_pct = $urandom_range(0, 3) * 12;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (in_bus.valid && !in_taken) begin
      // beat still offered, keep it stable
    end else if (in_gap > 0) begin
      in_gap--;
      in_bus.valid <= 1'b0;
    end else if (pending_bytes.size() == 0) begin
      in_bus.valid <= 1'b0;
    end else if (pending_bytes[0].drain_before && expected_chars.size() != 0) begin
      in_bus.valid <= 1'b0;
    end else if (!quiet && !hold_off && $urandom_range(0, 99) < in_idle_pct) begin
      in_gap = $urandom_range(0, 12);
      in_bus.valid <= 1'b0;
    end else begin
      in_bus.valid     <= 1'b1;
      in_bus.data_byte <= pending_bytes[0].data;
      in_bus.last_byte <= pending_bytes[0].last;
    end
  end

  // Character sink
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) out_idle_pct = $urandom_range(0, 3) * 12;
    if (!rst_ni || hold_off) begin
      out_bus.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_bus.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < out_idle_pct) begin
      out_gap = $urandom_range(0, 12);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Long sink stall while bytes keep coming, to back the block up.
  initial begin
    hold_off = 1'b0;
    wait (beats_sent >= HOLD_AT_BEAT);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** hex_ascii_frame_encoder_lrc: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [ByteW-1:0] dir_data [0:19];
    logic             dir_last [0:19];
    logic [ByteW-1:0] corner [0:5];
    logic [ByteW-1:0] b;
    int unsigned      len;
    bit               drained;

    // one-byte frames, a typical request, sum wrap, all digits, zero sum
    dir_data = '{8'h00, 8'hFF, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h0A,
                 8'hFF, 8'hFF, 8'h80, 8'h9A, 8'hB5, 8'hC6, 8'hD7, 8'hE8,
                 8'hF2, 8'h4E, 8'h12, 8'hEE};
    dir_last = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                 1'b0, 1'b1, 1'b0, 1'b1};
    corner   = '{8'h00, 8'hFF, 8'h09, 8'h0A, 8'h90, 8'hA0};

    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = '0;
    in_bus.last_byte  = 1'b0;
    out_bus.ready     = 1'b0;
    frame_sum         = '0;
    beats_sent        = 0;
    mismatches        = 0;
    cycle_cnt         = 0;
    in_gap            = 0;
    out_gap           = 0;
    in_idle_pct       = 0;
    out_idle_pct      = 24;
    in_taken          = 1'b0;
    quiet             = 1'b0;
    drained           = 1'b0;

    for (int i = 0; i < 20; i++) add_byte(dir_data[i], dir_last[i], 1'b0);

    // random frames, mostly short, now and then long
    while (pending_bytes.size() < ITEM_TARGET) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        b = ($urandom_range(0, 7) == 0) ? corner[$urandom_range(0, 5)]
                                         : ByteW'($urandom_range(0, 255));
        add_byte(b, (i == len - 1), (i == 0) && !drained &&
                 pending_bytes.size() >= DRAIN_AT_BEAT);
        // only a marked frame start counts as the drain point
        if (i == 0 && pending_bytes.size() > DRAIN_AT_BEAT) drained = 1'b1;
      end
    end
    n_total = pending_bytes.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (beats_sent < n_total || expected_chars.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("** hex_ascii_frame_encoder_lrc: PASSED **");
    end else begin
      $display("** hex_ascii_frame_encoder_lrc: FAILED **");
    end
    $finish;
  end

endmodule
